// ----- hw/rtl/apjb_pkg.sv -----
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// apjb_pkg
// Shared constants, codes and control types of the audio packet jitter buffer.
// ----------------------------------------------------------------------------
package apjb_pkg;

    // default sizes
    localparam int RING_DEPTH_DEF = 32768;
    localparam int MAX_PACKET_DEF = 2048;

    // item function codes
    localparam logic [1:0] FUNC_BYTE = 2'd0;
    localparam logic [1:0] FUNC_PULL = 2'd1;
    localparam logic [1:0] FUNC_TICK = 2'd2;

    // packet status codes
    localparam logic [2:0] ST_NONE        = 3'd0;
    localparam logic [2:0] ST_ACCEPTED    = 3'd1;
    localparam logic [2:0] ST_BAD_MAGIC   = 3'd2;
    localparam logic [2:0] ST_BAD_VERSION = 3'd3;
    localparam logic [2:0] ST_TOO_SHORT   = 3'd4;
    localparam logic [2:0] ST_RAGGED      = 3'd5;
    localparam logic [2:0] ST_NO_ROOM     = 3'd6;

    // packet format
    localparam logic [15:0] PKT_MAGIC       = 16'h5A4B;
    localparam logic [7:0]  PKT_VERSION_MAX = 8'd1;
    localparam int          PKT_HEADER      = 20;
    localparam int          PKT_HDR_KEEP    = 3;

    // configuration register indexes
    localparam logic [1:0] CFG_IDLE_TIMEOUT  = 2'd0;
    localparam logic [1:0] CFG_START_FILL    = 2'd1;
    localparam logic [1:0] CFG_PERIOD_LENGTH = 2'd2;

    // configuration reset values
    localparam logic [15:0] IDLE_TIMEOUT_RST  = 16'd5;
    localparam logic [14:0] START_FILL_RST    = 15'd720;
    localparam logic [12:0] PERIOD_LENGTH_RST = 13'd240;

    localparam logic [15:0] SILENT_MAX = 16'hFFFF;

    typedef struct packed {
        logic       commit;
        logic [2:0] status;
    } pkt_ctl_t;

    typedef struct packed {
        logic pop;
        logic frame_real;
        logic playing;
        logic started;
    } play_ctl_t;

endpackage
`default_nettype wire

// ----- hw/rtl/apjb_ring_ram.sv -----
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// apjb_ring_ram
// Frame ring storage, one write and one registered read port.
// ----------------------------------------------------------------------------
module apjb_ring_ram #(
    parameter int RING_DEPTH = apjb_pkg::RING_DEPTH_DEF
) (
    input  wire logic                          clk,
    input  wire logic                          wr_en,
    input  wire logic [$clog2(RING_DEPTH)-1:0] wr_addr,
    input  wire logic [31:0]                   wr_data,
    input  wire logic                          rd_en,
    input  wire logic [$clog2(RING_DEPTH)-1:0] rd_addr,
    output logic      [31:0]                   rd_data
);

    logic [31:0] mem [RING_DEPTH];
    logic [31:0] rd_data_reg;

    always_ff @(posedge clk)
    begin
        if (wr_en)
        begin
            mem[wr_addr] <= wr_data;
        end
        if (rd_en)
        begin
            rd_data_reg <= mem[rd_addr];
        end
    end

    assign rd_data = rd_data_reg;

endmodule
`default_nettype wire

// ----- hw/rtl/apjb_packet.sv -----
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// apjb_packet
// Packet byte parser: header capture, frame assembly, tentative ring writes
// and the end-of-packet verdict.
// ----------------------------------------------------------------------------
module apjb_packet #(
    parameter int RING_DEPTH = apjb_pkg::RING_DEPTH_DEF,
    parameter int MAX_PACKET = apjb_pkg::MAX_PACKET_DEF
) (
    input  wire logic                                clk,
    input  wire logic                                rst_n,
    input  wire logic                                en,
    input  wire logic [7:0]                          data_byte,
    input  wire logic                                last_byte,
    input  wire logic [$clog2(RING_DEPTH)-1:0]       wr_ptr,
    input  wire logic [$clog2(RING_DEPTH)-1:0]       fill,
    output logic                                     ram_we,
    output logic      [$clog2(RING_DEPTH)-1:0]       ram_addr,
    output logic      [31:0]                         ram_data,
    output logic      [$clog2(MAX_PACKET/4+1)-1:0]   commit_frames,
    output apjb_pkg::pkt_ctl_t                       ctl
);

    localparam int AW = $clog2(RING_DEPTH);
    localparam int SW = AW + 1;
    localparam int BW = $clog2(MAX_PACKET + 1);
    localparam int PW = $clog2(MAX_PACKET / 4 + 1);

    logic [BW-1:0] count_reg, count_next;
    logic [23:0]   header_reg, header_next;
    logic [23:0]   asm_reg, asm_next;
    logic [PW-1:0] pend_reg, pend_next;
    logic          lost_reg, lost_next;

    logic [BW-1:0] rel_pos;
    logic [BW-1:0] rel_end;
    logic [1:0]    k;
    logic [SW-1:0] room_sum;
    logic [SW-1:0] addr_sum;
    logic          in_range;

    assign in_range = count_reg < BW'(MAX_PACKET);
    assign rel_pos  = count_reg - BW'(apjb_pkg::PKT_HEADER);
    assign k        = rel_pos[1:0];
    assign room_sum = SW'(fill) + SW'(pend_reg);
    assign ram_data = {data_byte, asm_reg};

    // tentative slot sits pend_reg frames past the committed write pointer
    always_comb
    begin
        addr_sum = SW'(wr_ptr) + SW'(pend_reg);
        if (addr_sum >= SW'(RING_DEPTH))
        begin
            addr_sum = addr_sum - SW'(RING_DEPTH);
        end
        ram_addr = addr_sum[AW-1:0];
    end

    always_comb
    begin
        count_next    = count_reg;
        header_next   = header_reg;
        asm_next      = asm_reg;
        pend_next     = pend_reg;
        lost_next     = lost_reg;
        ram_we        = 1'b0;
        commit_frames = pend_reg;
        rel_end       = '0;
        ctl           = '0;
        if (en)
        begin
            if (in_range)
            begin
                count_next = count_reg + BW'(1);
                if (count_reg < BW'(apjb_pkg::PKT_HDR_KEEP))
                begin
                    header_next[8*count_reg[1:0] +: 8] = data_byte;
                end
                else if (count_reg >= BW'(apjb_pkg::PKT_HEADER))
                begin
                    if (k != 2'd3)
                    begin
                        asm_next[8*k +: 8] = data_byte;
                    end
                    else
                    begin
                        asm_next = '0;
                        if (!lost_reg && room_sum < SW'(RING_DEPTH - 1))
                        begin
                            ram_we    = 1'b1;
                            pend_next = pend_reg + PW'(1);
                        end
                        else
                        begin
                            lost_next = 1'b1;
                        end
                    end
                end
            end
            if (last_byte)
            begin
                rel_end       = count_next - BW'(apjb_pkg::PKT_HEADER);
                commit_frames = pend_next;
                if (count_next <= BW'(apjb_pkg::PKT_HEADER))
                begin
                    ctl.status = apjb_pkg::ST_TOO_SHORT;
                end
                else if (header_next[15:0] != apjb_pkg::PKT_MAGIC)
                begin
                    ctl.status = apjb_pkg::ST_BAD_MAGIC;
                end
                else if (header_next[23:16] > apjb_pkg::PKT_VERSION_MAX)
                begin
                    ctl.status = apjb_pkg::ST_BAD_VERSION;
                end
                else if (rel_end[1:0] != 2'd0)
                begin
                    ctl.status = apjb_pkg::ST_RAGGED;
                end
                else if (lost_next)
                begin
                    ctl.status = apjb_pkg::ST_NO_ROOM;
                end
                else
                begin
                    ctl.status = apjb_pkg::ST_ACCEPTED;
                    ctl.commit = 1'b1;
                end
                count_next  = '0;
                header_next = '0;
                asm_next    = '0;
                pend_next   = '0;
                lost_next   = 1'b0;
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            count_reg  <= '0;
            header_reg <= '0;
            asm_reg    <= '0;
            pend_reg   <= '0;
            lost_reg   <= 1'b0;
        end
        else
        begin
            count_reg  <= count_next;
            header_reg <= header_next;
            asm_reg    <= asm_next;
            pend_reg   <= pend_next;
            lost_reg   <= lost_next;
        end
    end

endmodule
`default_nettype wire

// ----- hw/rtl/apjb_playout.sv -----
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// apjb_playout
// Pull side: start threshold, frame pop, period counting and the
// playing/idle decision from silence and elapsed seconds.
// ----------------------------------------------------------------------------
module apjb_playout #(
    parameter int RING_DEPTH = apjb_pkg::RING_DEPTH_DEF
) (
    input  wire logic                          clk,
    input  wire logic                          rst_n,
    input  wire logic                          pull,
    input  wire logic                          tick,
    input  wire logic [$clog2(RING_DEPTH)-1:0] fill,
    input  wire logic [31:0]                   rd_data,
    input  wire logic [15:0]                   idle_timeout,
    input  wire logic [14:0]                   start_fill,
    input  wire logic [12:0]                   period_length,
    output apjb_pkg::play_ctl_t                ctl
);

    localparam int AW = $clog2(RING_DEPTH);
    localparam int CW = (AW > 15) ? AW : 15;

    logic        started_reg, started_next;
    logic        playing_reg, playing_next;
    logic [15:0] silent_reg, silent_next;
    logic [12:0] pcount_reg, pcount_next;
    logic        audio_reg, audio_next;

    logic [12:0] pcount_inc;
    logic        fill_ge;

    assign fill_ge    = CW'(fill) >= CW'(start_fill);
    assign pcount_inc = pcount_reg + 13'd1;

    always_comb
    begin
        started_next = started_reg;
        playing_next = playing_reg;
        silent_next  = silent_reg;
        pcount_next  = pcount_reg;
        audio_next   = audio_reg;
        ctl          = '0;
        if (pull)
        begin
            if (!started_reg && fill_ge)
            begin
                started_next = 1'b1;
                playing_next = 1'b1;
                silent_next  = '0;
            end
            if (started_next)
            begin
                if (fill != '0)
                begin
                    ctl.pop        = 1'b1;
                    ctl.frame_real = 1'b1;
                    if (rd_data != '0)
                    begin
                        audio_next = 1'b1;
                    end
                end
                // end of period
                if (pcount_inc >= period_length)
                begin
                    if (audio_next)
                    begin
                        silent_next  = '0;
                        playing_next = 1'b1;
                    end
                    else if (playing_next && silent_next >= idle_timeout)
                    begin
                        playing_next = 1'b0;
                    end
                    pcount_next = '0;
                    audio_next  = 1'b0;
                end
                else
                begin
                    pcount_next = pcount_inc;
                end
            end
        end
        if (tick && silent_reg != apjb_pkg::SILENT_MAX)
        begin
            silent_next = silent_reg + 16'd1;
        end
        ctl.playing = playing_next;
        ctl.started = started_next;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            started_reg <= 1'b0;
            playing_reg <= 1'b0;
            silent_reg  <= '0;
            pcount_reg  <= '0;
            audio_reg   <= 1'b0;
        end
        else
        begin
            started_reg <= started_next;
            playing_reg <= playing_next;
            silent_reg  <= silent_next;
            pcount_reg  <= pcount_next;
            audio_reg   <= audio_next;
        end
    end

endmodule
`default_nettype wire

// ----- hw/rtl/audio_packet_jitter_buffer_core.sv -----
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// audio_packet_jitter_buffer_core
// Jitter buffer for stereo 16-bit PCM frames carried in packets.
//
// Items come in on the item channel (item_valid / item_stall): a packet byte,
// a frame pull or a one-second tick. Every item gives exactly one result on
// the result channel (result_valid / result_stall) with the pulled samples,
// the packet verdict on a last byte, the playing/started flags and the fill.
// No new item is taken while one is in flight: the pull has to wait on the
// registered read of the frame ring before its flags can be decided. A
// stalled result holds in the output register; the item in flight waits
// behind it and item_stall stays high until the register frees up.
// Configuration writes (cfg_valid / cfg_ready, always ready) must go in
// only while no item is in flight; the block does not enforce this. Reset
// clears pointers, flags, counters and the configuration to its defaults;
// ring contents are not cleared, as only committed entries are ever read.
// ----------------------------------------------------------------------------
module audio_packet_jitter_buffer_core #(
    parameter int RING_DEPTH = apjb_pkg::RING_DEPTH_DEF,
    parameter int MAX_PACKET = apjb_pkg::MAX_PACKET_DEF
) (
    input  wire logic               clk,
    input  wire logic               rst_n,
    input  wire logic               item_valid,
    output logic                    item_stall,
    input  wire logic [1:0]         func,
    input  wire logic [7:0]         data_byte,
    input  wire logic               last_byte,
    output logic                    result_valid,
    input  wire logic               result_stall,
    output logic signed [15:0]      left_sample,
    output logic signed [15:0]      right_sample,
    output logic                    frame_real,
    output logic        [2:0]       packet_status,
    output logic                    playing,
    output logic                    started,
    output logic        [14:0]      fill_frames,
    input  wire logic               cfg_valid,
    output logic                    cfg_ready,
    input  wire logic [1:0]         cfg_index,
    input  wire logic [15:0]        cfg_data
);

    localparam int AW = $clog2(RING_DEPTH);
    localparam int SW = AW + 1;
    localparam int PW = $clog2(MAX_PACKET / 4 + 1);

    function automatic logic [AW-1:0] ring_fill(input logic [AW-1:0] w, input logic [AW-1:0] r);
        logic [SW-1:0] d;
        d = SW'(w) - SW'(r);
        if (w < r)
        begin
            d = d + SW'(RING_DEPTH);
        end
        return d[AW-1:0];
    endfunction

    function automatic logic [AW-1:0] ring_adv(input logic [AW-1:0] p, input logic [SW-1:0] n);
        logic [SW-1:0] s;
        s = SW'(p) + n;
        if (s >= SW'(RING_DEPTH))
        begin
            s = s - SW'(RING_DEPTH);
        end
        return s[AW-1:0];
    endfunction

    // configuration
    logic [15:0] idle_timeout_reg;
    logic [14:0] start_fill_reg;
    logic [12:0] period_length_reg;

    // ring pointers
    logic [AW-1:0] wp_reg, wp_next;
    logic [AW-1:0] rp_reg, rp_next;
    logic [AW-1:0] fill_now;

    // item in flight
    logic       busy_reg, busy_next;
    logic [1:0] func_reg;
    logic [7:0] byte_reg;
    logic       last_reg;

    // result register
    logic        res_valid_reg, res_valid_next;
    logic [15:0] left_reg, right_reg;
    logic        real_reg;
    logic [2:0]  status_reg;
    logic        playing_reg;
    logic        started_reg;
    logic [14:0] fill_reg;

    logic item_xfer;
    logic res_blocked;
    logic go;

    logic          ram_we;
    logic [AW-1:0] ram_waddr;
    logic [31:0]   ram_wdata;
    logic [31:0]   ram_rdata;
    logic [PW-1:0] commit_frames;

    apjb_pkg::pkt_ctl_t  pkt_ctl;
    apjb_pkg::play_ctl_t play_ctl;

    assign res_blocked = res_valid_reg & result_stall;
    assign item_stall  = busy_reg | res_blocked;
    assign item_xfer   = item_valid & ~item_stall;
    assign go          = busy_reg & ~res_blocked;
    assign fill_now    = ring_fill(wp_reg, rp_reg);
    assign cfg_ready   = 1'b1;

    apjb_ring_ram #(
        .RING_DEPTH (RING_DEPTH)
    ) u_ram (
        .clk     (clk),
        .wr_en   (ram_we),
        .wr_addr (ram_waddr),
        .wr_data (ram_wdata),
        .rd_en   (item_xfer && func == apjb_pkg::FUNC_PULL),
        .rd_addr (rp_reg),
        .rd_data (ram_rdata)
    );

    apjb_packet #(
        .RING_DEPTH (RING_DEPTH),
        .MAX_PACKET (MAX_PACKET)
    ) u_packet (
        .clk           (clk),
        .rst_n         (rst_n),
        .en            (go && func_reg == apjb_pkg::FUNC_BYTE),
        .data_byte     (byte_reg),
        .last_byte     (last_reg),
        .wr_ptr        (wp_reg),
        .fill          (fill_now),
        .ram_we        (ram_we),
        .ram_addr      (ram_waddr),
        .ram_data      (ram_wdata),
        .commit_frames (commit_frames),
        .ctl           (pkt_ctl)
    );

    apjb_playout #(
        .RING_DEPTH (RING_DEPTH)
    ) u_playout (
        .clk           (clk),
        .rst_n         (rst_n),
        .pull          (go && func_reg == apjb_pkg::FUNC_PULL),
        .tick          (go && func_reg == apjb_pkg::FUNC_TICK),
        .fill          (fill_now),
        .rd_data       (ram_rdata),
        .idle_timeout  (idle_timeout_reg),
        .start_fill    (start_fill_reg),
        .period_length (period_length_reg),
        .ctl           (play_ctl)
    );

    always_comb
    begin
        wp_next = wp_reg;
        rp_next = rp_reg;
        if (pkt_ctl.commit)
        begin
            wp_next = ring_adv(wp_reg, SW'(commit_frames));
        end
        if (play_ctl.pop)
        begin
            rp_next = ring_adv(rp_reg, SW'(1));
        end
    end

    always_comb
    begin
        busy_next = busy_reg;
        if (item_xfer)
        begin
            busy_next = 1'b1;
        end
        else if (go)
        begin
            busy_next = 1'b0;
        end
        res_valid_next = res_valid_reg;
        if (go)
        begin
            res_valid_next = 1'b1;
        end
        else if (res_valid_reg && !result_stall)
        begin
            res_valid_next = 1'b0;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            busy_reg          <= 1'b0;
            res_valid_reg     <= 1'b0;
            wp_reg            <= '0;
            rp_reg            <= '0;
            idle_timeout_reg  <= apjb_pkg::IDLE_TIMEOUT_RST;
            start_fill_reg    <= apjb_pkg::START_FILL_RST;
            period_length_reg <= apjb_pkg::PERIOD_LENGTH_RST;
        end
        else
        begin
            busy_reg      <= busy_next;
            res_valid_reg <= res_valid_next;
            wp_reg        <= wp_next;
            rp_reg        <= rp_next;
            if (cfg_valid && cfg_ready)
            begin
                unique case (cfg_index)
                    apjb_pkg::CFG_IDLE_TIMEOUT:  idle_timeout_reg  <= cfg_data;
                    apjb_pkg::CFG_START_FILL:    start_fill_reg    <= cfg_data[14:0];
                    apjb_pkg::CFG_PERIOD_LENGTH: period_length_reg <= cfg_data[12:0];
                    default:
                    begin
                    end
                endcase
            end
        end
    end

    // payload registers
    always_ff @(posedge clk)
    begin
        if (item_xfer)
        begin
            func_reg <= func;
            byte_reg <= data_byte;
            last_reg <= last_byte;
        end
        if (go)
        begin
            left_reg    <= play_ctl.frame_real ? ram_rdata[15:0] : 16'd0;
            right_reg   <= play_ctl.frame_real ? ram_rdata[31:16] : 16'd0;
            real_reg    <= play_ctl.frame_real;
            status_reg  <= pkt_ctl.status;
            playing_reg <= play_ctl.playing;
            started_reg <= play_ctl.started;
            fill_reg    <= 15'(ring_fill(wp_next, rp_next));
        end
    end

    assign result_valid  = res_valid_reg;
    assign left_sample   = left_reg;
    assign right_sample  = right_reg;
    assign frame_real    = real_reg;
    assign packet_status = status_reg;
    assign playing       = playing_reg;
    assign started       = started_reg;
    assign fill_frames   = fill_reg;

endmodule
`default_nettype wire
